// ----- sv/triangle_plane_clipper_top_macros.svh -----
// Assertion macros for the triangle plane clipper.
// Used by tpc_merge in this folder; they need clk and arst_n in scope.
`ifndef TRIANGLE_PLANE_CLIPPER_TOP_MACROS_SVH
`define TRIANGLE_PLANE_CLIPPER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tpc_pkg.sv -----
// Shared codes and types for the triangle plane clipper.
// No dependencies; tpc_merge and the top level refer to it by scoped names.
`default_nettype none
package tpc_pkg;

	localparam int NUM_REGS = 6;

	localparam logic [2:0] REG_PX = 3'd0;
	localparam logic [2:0] REG_PY = 3'd1;
	localparam logic [2:0] REG_PZ = 3'd2;
	localparam logic [2:0] REG_NX = 3'd3;
	localparam logic [2:0] REG_NY = 3'd4;
	localparam logic [2:0] REG_NZ = 3'd5;

	// How many vertices of the triangle lie on the inside of the plane.
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ONE  = 2'd1;
	localparam logic [1:0] KIND_TWO  = 2'd2;
	localparam logic [1:0] KIND_ALL  = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
	} ctl_t;

endpackage
`default_nettype wire

// ----- sv/tpc_if.sv -----
// Stream interfaces of the triangle plane clipper: triangle in, triangle out.
// Depends on nothing; used by the merge stage and the top level.
`default_nettype none
interface tpc_vin_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic [W-1:0] a_x, a_y, a_z;
	logic [W-1:0] b_x, b_y, b_z;
	logic [W-1:0] c_x, c_y, c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

interface tpc_vout_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic [W-1:0] out_a_x, out_a_y, out_a_z;
	logic [W-1:0] out_b_x, out_b_y, out_b_z;
	logic [W-1:0] out_c_x, out_c_y, out_c_z;
	logic last_piece;

	modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
		out_c_x, out_c_y, out_c_z, last_piece, input ready);
	modport sink (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
		out_c_x, out_c_y, out_c_z, last_piece, output ready);
endinterface
`default_nettype wire

// ----- sv/tpc_dist_lane.sv -----
// Signed plane distance of one vertex, n.(v - P), exact, over three stages.
// Depends on nothing else; instantiated once per vertex by the top level.
`default_nettype none
module tpc_dist_lane #(
	parameter int C = 32
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [2:0][C-1:0]   v,
	input  wire logic [2:0][C-1:0]   p,
	input  wire logic [2:0][C-1:0]   n,
	output logic signed [2*C+2:0]    s
);
	logic signed [C:0]     diff_s2 [3];
	logic signed [2*C:0]   prod_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				diff_s2[k] <= $signed({v[k][C-1], v[k]}) - $signed({p[k][C-1], p[k]});
				prod_s3[k] <= $signed({{C{diff_s2[k][C]}}, diff_s2[k]})
					* $signed({{(C+1){n[k][C-1]}}, n[k]});
			end
			s <= $signed({{2{prod_s3[0][2*C]}}, prod_s3[0]})
				+ $signed({{2{prod_s3[1][2*C]}}, prod_s3[1]})
				+ $signed({{2{prod_s3[2][2*C]}}, prod_s3[2]});
		end
	end
endmodule
`default_nettype wire

// ----- sv/tpc_cut_lane.sv -----
// One axis of one new vertex: base + sign * round(|d| * sI / den).
// Split multiply, then a restoring divider pipelined one quotient bit a stage.
`default_nettype none
module tpc_cut_lane #(
	parameter int C = 32
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [C-1:0]        base,
	input  wire logic signed [C:0]   diff,
	input  wire logic [2*C+2:0]      s_in,
	input  wire logic [2*C+2:0]      den,
	output logic [C-1:0]             res
);
	localparam int SW = 2 * C + 3;
	localparam int QB = C + 1;
	localparam int LO = (SW - 1) / 2;
	localparam int HI = SW - 1 - LO;
	localparam int NW = C + SW;

	logic [C:0]        mag_full;
	logic [C+LO-1:0]   pp_lo_m1;
	logic [C+HI-1:0]   pp_hi_m1;
	logic              neg_m1;
	logic [C-1:0]      base_m1;
	logic [SW-1:0]     den_m1;
	logic [NW-2:0]     num;
	logic [NW-1:0]     num2;

	logic [SW-1:0]     r_d    [QB+1];
	logic [QB-1:0]     l_d    [QB+1];
	logic [SW-1:0]     den_d  [QB+1];
	logic [C-1:0]      base_d [QB+1];
	logic              neg_d  [QB+1];
	logic [QB:0]       q_inc;

	assign mag_full = diff[C] ? (~diff + 1'b1) : diff;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_m1 <= {{LO{1'b0}}, mag_full[C-1:0]} * {{C{1'b0}}, s_in[LO-1:0]};
			pp_hi_m1 <= {{HI{1'b0}}, mag_full[C-1:0]} * {{C{1'b0}}, s_in[SW-2:LO]};
			neg_m1   <= diff[C];
			base_m1  <= base;
			den_m1   <= den;
		end
	end

	// Twice the numerator, so that the quotient carries one extra bit for rounding.
	assign num  = {pp_hi_m1, {LO{1'b0}}} + (NW-1)'(pp_lo_m1);
	assign num2 = {num, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			r_d[0]    <= SW'(num2[NW-1:QB]);
			l_d[0]    <= num2[QB-1:0];
			den_d[0]  <= den_m1;
			base_d[0] <= base_m1;
			neg_d[0]  <= neg_m1;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [SW:0] t;
		logic [SW:0] t_sub;
		logic        ge;

		assign t     = {r_d[j], l_d[j][QB-1]};
		assign t_sub = t - {1'b0, den_d[j]};
		assign ge    = (t >= {1'b0, den_d[j]});

		always_ff @(posedge clk) begin
			if (en) begin
				r_d[j+1]    <= ge ? t_sub[SW-1:0] : t[SW-1:0];
				l_d[j+1]    <= {l_d[j][QB-2:0], ge};
				den_d[j+1]  <= den_d[j];
				base_d[j+1] <= base_d[j];
				neg_d[j+1]  <= neg_d[j];
			end
		end
	end

	// Halving the doubled quotient after adding one rounds ties away from zero.
	assign q_inc = {1'b0, l_d[QB]} + 1'b1;

	always_ff @(posedge clk) begin
		if (en) begin
			res <= neg_d[QB] ? (base_d[QB] - q_inc[C:1]) : (base_d[QB] + q_inc[C:1]);
		end
	end
endmodule
`default_nettype wire

// ----- sv/tpc_merge.sv -----
// Assembles the result triangles from pass-through and new vertices and
// holds them in the output register. Depends on tpc_pkg, tpc_if and the assertion macros.
`default_nettype none
`include "triangle_plane_clipper_top_macros.svh"
module tpc_merge #(
	parameter int C = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tpc_pkg::ctl_t      ctl,
	input  wire logic [2:0][C-1:0]  pv [3],
	input  wire logic [2:0][C-1:0]  x0,
	input  wire logic [2:0][C-1:0]  x1,
	output logic                    en,
	tpc_vout_if.source              vout
);
	logic                 ovalid_q;
	logic                 sel_q;
	logic [1:0]           kind_q;
	logic [2:0][C-1:0]    tri0_q [3];
	logic [2:0][C-1:0]    tri1_q [3];
	logic [2:0][C-1:0]    tri0_d [3];
	logic [2:0][C-1:0]    tri1_d [3];
	logic                 last;
	logic                 load;

	always_comb begin
		tri0_d[0] = pv[0];
		tri0_d[1] = pv[1];
		tri0_d[2] = pv[2];
		tri1_d[0] = pv[1];
		tri1_d[1] = x0;
		tri1_d[2] = x1;
		case (ctl.kind)
			tpc_pkg::KIND_ONE: begin
				tri0_d[1] = x0;
				tri0_d[2] = x1;
			end
			tpc_pkg::KIND_TWO: begin
				tri0_d[2] = x0;
			end
			default: begin
			end
		endcase
	end

	assign last = sel_q || (kind_q != tpc_pkg::KIND_TWO);
	assign en   = !ovalid_q || (vout.ready && last);
	assign load = ctl.valid && (ctl.kind != tpc_pkg::KIND_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			sel_q    <= 1'b0;
			kind_q   <= tpc_pkg::KIND_NONE;
		end else if (en) begin
			ovalid_q <= load;
			sel_q    <= 1'b0;
			kind_q   <= ctl.kind;
		end else if (vout.ready) begin
			// First of two triangles taken; show the second.
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && load) begin
			tri0_q <= tri0_d;
			tri1_q <= tri1_d;
		end
	end

	assign vout.valid      = ovalid_q;
	assign vout.last_piece = last;
	assign vout.out_a_x    = sel_q ? tri1_q[0][0] : tri0_q[0][0];
	assign vout.out_a_y    = sel_q ? tri1_q[0][1] : tri0_q[0][1];
	assign vout.out_a_z    = sel_q ? tri1_q[0][2] : tri0_q[0][2];
	assign vout.out_b_x    = sel_q ? tri1_q[1][0] : tri0_q[1][0];
	assign vout.out_b_y    = sel_q ? tri1_q[1][1] : tri0_q[1][1];
	assign vout.out_b_z    = sel_q ? tri1_q[1][2] : tri0_q[1][2];
	assign vout.out_c_x    = sel_q ? tri1_q[2][0] : tri0_q[2][0];
	assign vout.out_c_y    = sel_q ? tri1_q[2][1] : tri0_q[2][1];
	assign vout.out_c_z    = sel_q ? tri1_q[2][2] : tri0_q[2][2];

	`TPC_ASSERT_IMP(a_sel_two, sel_q, ovalid_q && (kind_q == tpc_pkg::KIND_TWO), "second triangle shown for a single-triangle request")
	`TPC_ASSERT_NXT(a_split, ovalid_q && vout.ready && !last, ovalid_q && sel_q, "second triangle lost after the first was taken")
	`TPC_ASSERT_NXT(a_load, en && load, ovalid_q && !sel_q, "result request not loaded into the output register")
	`TPC_ASSERT_NXT(a_empty, en && !load, !ovalid_q, "output register valid without a result request")
endmodule
`default_nettype wire

// ----- sv/triangle_plane_clipper_top.sv -----
// Throughput: one triangle per cycle while vout is ready and each triangle yields at most
// one result; one that yields two holds the pipeline until both its results are taken.
// Reset: the plane returns to point (0, 0, 1.0) and normal (0, 0, 1.0); the pipeline empties.
// Depends on tpc_pkg, tpc_if, tpc_dist_lane, tpc_cut_lane and tpc_merge.
`default_nettype none
module triangle_plane_clipper_top #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16,
	localparam int PDW  = (COORD_BITS > 32) ? 64 : 32,
	localparam int ASTEP = (COORD_BITS > 32) ? 3 : 2,
	localparam int PAW  = ASTEP + 3
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [PAW-1:0]  paddr,
	input  wire logic [PDW-1:0]  pwdata,
	output logic [PDW-1:0]       prdata,
	output logic                 pready,
	tpc_vin_if.sink              vin,
	tpc_vout_if.source           vout
);
	localparam int C   = COORD_BITS;
	localparam int SW  = 2 * C + 3;
	localparam int LAT = C + 4;

	// Configuration registers.
	logic [C-1:0] cfg_q [tpc_pkg::NUM_REGS];
	logic [2:0]   cfg_idx;

	assign cfg_idx = paddr[PAW-1:ASTEP];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[tpc_pkg::REG_PX] <= '0;
			cfg_q[tpc_pkg::REG_PY] <= '0;
			cfg_q[tpc_pkg::REG_PZ] <= C'(64'd1 << FRAC_BITS);
			cfg_q[tpc_pkg::REG_NX] <= '0;
			cfg_q[tpc_pkg::REG_NY] <= '0;
			cfg_q[tpc_pkg::REG_NZ] <= C'(64'd1 << FRAC_BITS);
		end else if (psel && penable && pwrite && (cfg_idx < 3'(tpc_pkg::NUM_REGS))) begin
			cfg_q[cfg_idx] <= pwdata[C-1:0];
		end
	end

	assign prdata = (cfg_idx < 3'(tpc_pkg::NUM_REGS)) ? PDW'(cfg_q[cfg_idx]) : '0;

	logic [2:0][C-1:0] plane_p, plane_n;
	assign plane_p = {cfg_q[tpc_pkg::REG_PZ], cfg_q[tpc_pkg::REG_PY], cfg_q[tpc_pkg::REG_PX]};
	assign plane_n = {cfg_q[tpc_pkg::REG_NZ], cfg_q[tpc_pkg::REG_NY], cfg_q[tpc_pkg::REG_NX]};

	logic en;
	assign vin.ready = en;

	// Input register and vertex delay alongside the distance lanes.
	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [2:0][C-1:0] v_s1 [3];
	logic [2:0][C-1:0] v_s2 [3];
	logic [2:0][C-1:0] v_s3 [3];
	logic [2:0][C-1:0] v_s4 [3];
	logic signed [SW-1:0] s_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1[0] <= {vin.a_z, vin.a_y, vin.a_x};
			v_s1[1] <= {vin.b_z, vin.b_y, vin.b_x};
			v_s1[2] <= {vin.c_z, vin.c_y, vin.c_x};
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_dist
		tpc_dist_lane #(.C(C)) u_dist (
			.clk (clk),
			.en  (en),
			.v   (v_s1[i]),
			.p   (plane_p),
			.n   (plane_n),
			.s   (s_s4[i])
		);
	end

	// Classify the vertices and pick the edges to cut.
	logic [2:0]        ins;
	logic [1:0]        kind_d;
	logic [2:0][C-1:0] pv_d [3];
	logic [2:0][C-1:0] ci_d [2];
	logic [2:0][C-1:0] co_d [2];
	logic [SW-1:0]     si_d [2];
	logic [SW-1:0]     so_d [2];

	assign ins = {~s_s4[2][SW-1], ~s_s4[1][SW-1], ~s_s4[0][SW-1]};

	always_comb begin
		kind_d = tpc_pkg::KIND_NONE;
		pv_d   = v_s4;
		ci_d[0] = v_s4[0];
		ci_d[1] = v_s4[0];
		co_d[0] = v_s4[1];
		co_d[1] = v_s4[2];
		si_d[0] = s_s4[0];
		si_d[1] = s_s4[0];
		so_d[0] = s_s4[1];
		so_d[1] = s_s4[2];
		case (ins)
			3'b111: kind_d = tpc_pkg::KIND_ALL;
			3'b001: kind_d = tpc_pkg::KIND_ONE;
			3'b010: begin
				kind_d  = tpc_pkg::KIND_ONE;
				pv_d[0] = v_s4[1];
				ci_d[0] = v_s4[1];
				ci_d[1] = v_s4[1];
				co_d[0] = v_s4[0];
				si_d[0] = s_s4[1];
				si_d[1] = s_s4[1];
				so_d[0] = s_s4[0];
			end
			3'b100: begin
				kind_d  = tpc_pkg::KIND_ONE;
				pv_d[0] = v_s4[2];
				ci_d[0] = v_s4[2];
				ci_d[1] = v_s4[2];
				co_d[0] = v_s4[0];
				co_d[1] = v_s4[1];
				si_d[0] = s_s4[2];
				si_d[1] = s_s4[2];
				so_d[0] = s_s4[0];
				so_d[1] = s_s4[1];
			end
			3'b011: begin
				kind_d  = tpc_pkg::KIND_TWO;
				ci_d[1] = v_s4[1];
				co_d[0] = v_s4[2];
				si_d[1] = s_s4[1];
				so_d[0] = s_s4[2];
			end
			3'b101: begin
				kind_d  = tpc_pkg::KIND_TWO;
				pv_d[1] = v_s4[2];
				ci_d[1] = v_s4[2];
				co_d[1] = v_s4[1];
				si_d[1] = s_s4[2];
				so_d[1] = s_s4[1];
			end
			3'b110: begin
				kind_d  = tpc_pkg::KIND_TWO;
				pv_d[0] = v_s4[1];
				pv_d[1] = v_s4[2];
				ci_d[0] = v_s4[1];
				ci_d[1] = v_s4[2];
				co_d[0] = v_s4[0];
				co_d[1] = v_s4[0];
				si_d[0] = s_s4[1];
				si_d[1] = s_s4[2];
				so_d[0] = s_s4[0];
				so_d[1] = s_s4[0];
			end
			default: kind_d = tpc_pkg::KIND_NONE;
		endcase
	end

	logic [1:0]          kind_s5;
	logic [2:0][C-1:0]   pv_s5    [3];
	logic [2:0][C-1:0]   cbase_s5 [2];
	logic signed [C:0]   cdif_s5  [2][3];
	logic [SW-1:0]       csi_s5   [2];
	logic [SW-1:0]       cden_s5  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5 <= kind_d;
			pv_s5   <= pv_d;
			for (int c = 0; c < 2; c++) begin
				cbase_s5[c] <= ci_d[c];
				csi_s5[c]   <= si_d[c];
				cden_s5[c]  <= si_d[c] - so_d[c];
				for (int k = 0; k < 3; k++) begin
					cdif_s5[c][k] <= $signed({co_d[c][k][C-1], co_d[c][k]})
						- $signed({ci_d[c][k][C-1], ci_d[c][k]});
				end
			end
		end
	end

	// Six cut lanes: two new vertices, three axes each.
	logic [2:0][C-1:0] x_res [2];

	for (genvar c = 0; c < 2; c++) begin : g_cut
		for (genvar k = 0; k < 3; k++) begin : g_axis
			tpc_cut_lane #(.C(C)) u_cut (
				.clk  (clk),
				.en   (en),
				.base (cbase_s5[c][k]),
				.diff (cdif_s5[c][k]),
				.s_in (csi_s5[c]),
				.den  (cden_s5[c]),
				.res  (x_res[c][k])
			);
		end
	end

	// Request information delayed to meet the cut lanes.
	tpc_pkg::ctl_t     sd_ctl_q [LAT];
	logic [2:0][C-1:0] sd_pv_q  [LAT][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) sd_ctl_q[i] <= '0;
		end else if (en) begin
			sd_ctl_q[0] <= '{valid: valid_s5, kind: kind_s5};
			for (int i = 1; i < LAT; i++) sd_ctl_q[i] <= sd_ctl_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_pv_q[0] <= pv_s5;
			for (int i = 1; i < LAT; i++) sd_pv_q[i] <= sd_pv_q[i-1];
		end
	end

	tpc_merge #(.C(C)) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sd_ctl_q[LAT-1]),
		.pv     (sd_pv_q[LAT-1]),
		.x0     (x_res[0]),
		.x1     (x_res[1]),
		.en     (en),
		.vout   (vout)
	);
endmodule
`default_nettype wire
